[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PSDC_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property slot cache check failed");

// Condition that must never be seen outside reset.
`define PSDC_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("property slot cache forbidden condition seen");

`endif

[rtl/core/psdc_pkg.sv]
// ---------------------------------------------------------------------------
// psdc_pkg
// Types and constants of the property slot cache.
// ---------------------------------------------------------------------------
package psdc_pkg;

  localparam int OP_W    = 3;
  localparam int KEY_W   = 24;
  localparam int SLOT_W  = 16;
  localparam int PROTO_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_FILL_OWN    = 3'd0,
    OP_FILL_PROTO  = 3'd1,
    OP_LOAD        = 3'd2,
    OP_STORE       = 3'd3,
    OP_CLEAR       = 3'd4,
    OP_CLEAR_PROTO = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [SLOT_W-1:0]  slot;
    logic               inl;
    logic               store_ok;
    logic               absent;
    logic [PROTO_W-1:0] proto;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   id;
    logic [SLOT_W-1:0]  slot;
    logic               inl;
    logic               set_ok;
    logic               missing;
    logic [PROTO_W-1:0] proto;
    logic               check;
  } req_t;

  typedef struct packed {
    logic               en;
    entry_t             entry;
  } wr_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               inl;
    logic               missing;
    logic [PROTO_W-1:0] proto;
    logic               reg_needed;
  } result_t;

endpackage

[rtl/core/psdc_index.sv]
// ---------------------------------------------------------------------------
// psdc_index
// Reduces a property id modulo the table depth: reciprocal multiply into a
// register, then multiply back, subtract and one correction step.
// ---------------------------------------------------------------------------
module psdc_index import psdc_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic             clk,
  input  logic             mul_en,
  input  logic [KEY_W-1:0] id,
  output logic [IDX_W-1:0] idx
);

  localparam int SH = KEY_W + $clog2(ENTRIES);
  localparam logic [KEY_W:0] RECIP =
    (KEY_W+1)'(((64'd1 << SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));
  localparam logic [IDX_W:0] NVAL = (IDX_W+1)'(ENTRIES);

  logic [2*KEY_W:0]     prod;
  logic [KEY_W-1:0]     quot;
  logic [KEY_W+IDX_W:0] back;
  logic [KEY_W-1:0]     rem_full;
  logic [IDX_W:0]       rem_small;

  assign prod = {{KEY_W{1'b0}}, 1'b0, id} * {{KEY_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (mul_en) begin
      quot <= KEY_W'(prod >> SH);
    end
  end

  assign back      = {{(IDX_W+1){1'b0}}, quot} * {{KEY_W{1'b0}}, NVAL};
  assign rem_full  = id - back[KEY_W-1:0];
  assign rem_small = rem_full[IDX_W:0];

  // if the quotient came out one low, one subtract would fix the remainder
  always_comb begin
    if (rem_small >= NVAL) begin
      idx = IDX_W'(rem_small - NVAL);
    end else begin
      idx = rem_small[IDX_W-1:0];
    end
  end

endmodule

[rtl/core/psdc_store.sv]
// ---------------------------------------------------------------------------
// psdc_store
// Entry memory: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module psdc_store import psdc_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/psdc_exec.sv]
// ---------------------------------------------------------------------------
// psdc_exec
// Evaluates one request against the entry read from memory, produces the
// write-back and registers the result.
// ---------------------------------------------------------------------------
module psdc_exec import psdc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    exec_en,
  input  req_t    req,
  input  entry_t  rd,
  output wr_t     wr,
  output result_t res,
  output logic    strobe
);

  logic    match;
  logic    proto_zero;
  result_t res_next;

  assign match      = rd.valid && (rd.key == req.id);
  assign proto_zero = (rd.proto == '0);

  always_comb begin
    res_next = '0;
    wr.en    = 1'b0;
    wr.entry = rd;
    unique case (req.op)
      OP_FILL_OWN: begin
        wr.en    = 1'b1;
        wr.entry = '{valid: 1'b1, key: req.id, slot: req.slot, inl: req.inl,
                     store_ok: req.set_ok, absent: 1'b0, proto: '0};
      end
      OP_FILL_PROTO: begin
        res_next.reg_needed = !match || proto_zero;
        wr.en    = 1'b1;
        wr.entry = '{valid: 1'b1, key: req.id, slot: req.slot, inl: req.inl,
                     store_ok: req.set_ok, absent: req.missing, proto: req.proto};
      end
      OP_LOAD: begin
        if (match && (req.check || !rd.absent)) begin
          res_next.hit     = 1'b1;
          res_next.slot    = rd.slot;
          res_next.inl     = rd.inl;
          res_next.missing = req.check && rd.absent;
          res_next.proto   = rd.proto;
        end
      end
      OP_STORE: begin
        if (match && rd.store_ok && proto_zero) begin
          res_next.hit  = 1'b1;
          res_next.slot = rd.slot;
          res_next.inl  = rd.inl;
        end
      end
      OP_CLEAR: begin
        if (match) begin
          wr.en          = 1'b1;
          wr.entry.valid = 1'b0;
          res_next.hit   = 1'b1;
        end
      end
      OP_CLEAR_PROTO: begin
        if (match && !proto_zero) begin
          wr.en          = 1'b1;
          wr.entry.valid = 1'b0;
          res_next.hit   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= exec_en;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      res <= res_next;
    end
  end

endmodule

[rtl/core/property_slot_direct_mapped_cache_top.sv]
// ---------------------------------------------------------------------------
// property_slot_direct_mapped_cache_top
// Direct-mapped property slot cache with fill, lookup and clear requests.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on the result ports with done high for one cycle, and a new request can be
// taken in that same cycle. Busy stays high until then, so the block does not
// take a new request before the last one is through. The request passes in
// order through the reciprocal multiply of the index reduction, the registered
// read of the entry memory (its address comes from the multiply back and
// correction in that read step), the evaluate/write-back step that also loads
// the result register, and the showing of the result. After reset, busy stays
// high while a clearing pass invalidates every entry. Results cannot be held
// off; done marks the cycle in which a new result is first shown.
module property_slot_direct_mapped_cache_top import psdc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    operation,
  input  logic [KEY_W-1:0]   property_id,
  input  logic [SLOT_W-1:0]  slot_index,
  input  logic               inline_slot,
  input  logic               set_allowed,
  input  logic               missing_flag,
  input  logic [PROTO_W-1:0] proto_handle,
  input  logic               check_missing,
  output logic               done,
  output logic               hit,
  output logic [SLOT_W-1:0]  hit_slot_index,
  output logic               hit_inline,
  output logic               hit_missing,
  output logic [PROTO_W-1:0] hit_proto_handle,
  output logic               register_needed
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] clr_cnt;
  req_t             req;
  logic             accept;
  logic             mul_en;
  logic             exec_en;
  logic [IDX_W-1:0] idx;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  entry_t           rd;
  wr_t              wr;
  result_t          res;

  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy    = (state != ST_IDLE);
    mul_en  = (state == ST_MUL);
    exec_en = (state == ST_EXEC);
    we      = 1'b0;
    waddr   = idx;
    wdata   = wr.entry;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
      end
      ST_EXEC: begin
        we = wr.en;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= '{op: operation, id: property_id, slot: slot_index,
               inl: inline_slot, set_ok: set_allowed, missing: missing_flag,
               proto: proto_handle, check: check_missing};
    end
  end

  psdc_index #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_index (
    .clk    (clk),
    .mul_en (mul_en),
    .id     (req.id),
    .idx    (idx)
  );

  psdc_store #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rd)
  );

  psdc_exec u_exec (
    .clk     (clk),
    .rst     (rst),
    .exec_en (exec_en),
    .req     (req),
    .rd      (rd),
    .wr      (wr),
    .res     (res),
    .strobe  (done)
  );

  assign hit              = res.hit;
  assign hit_slot_index   = res.slot;
  assign hit_inline       = res.inl;
  assign hit_missing      = res.missing;
  assign hit_proto_handle = res.proto;
  assign register_needed  = res.reg_needed;

endmodule

[rtl/core/psdc_checker.sv]
// ---------------------------------------------------------------------------
// psdc_checker
// Port-level checks on request timing and result encoding.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psdc_checker import psdc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               hit,
  input logic [SLOT_W-1:0]  hit_slot_index,
  input logic [PROTO_W-1:0] hit_proto_handle,
  input logic               register_needed
);

  `PSDC_CHECK(a_accept_busy, (start && !busy) |=> busy)
  `PSDC_CHECK(a_accept_done, (start && !busy) |-> ##4 done)
  `PSDC_NEVER(a_done_busy, done && busy)
  `PSDC_NEVER(a_hit_reg, done && hit && register_needed)
  `PSDC_CHECK(a_miss_zero, (done && !hit) |-> (hit_slot_index == '0 && hit_proto_handle == '0))

endmodule

bind property_slot_direct_mapped_cache_top psdc_checker u_psdc_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .done             (done),
  .hit              (hit),
  .hit_slot_index   (hit_slot_index),
  .hit_proto_handle (hit_proto_handle),
  .register_needed  (register_needed)
);
